// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tlbsa_pkg.sv =====
`timescale 1ns / 1ps

package tlbsa_pkg;

  // Geometry. Words per group is kept a power of two.
  localparam int TOP_WORDS       = 1;
  localparam int WPG_LOG2        = 2;
  localparam int WORDS_PER_GROUP = 1 << WPG_LOG2;
  localparam int NUM_GROUPS      = TOP_WORDS * 64;
  localparam int GROUP_W         = $clog2(NUM_GROUPS);
  localparam int WSEL_W          = WPG_LOG2;
  localparam int NUM_WORDS       = NUM_GROUPS * WORDS_PER_GROUP;
  localparam int ADDR_W          = GROUP_W + WSEL_W;
  localparam int SLOT_BITS       = ADDR_W + 6;
  localparam int GROUP_SLOTS     = WORDS_PER_GROUP * 64;
  localparam int CNT_W           = $clog2(GROUP_SLOTS + 1);
  localparam int TOTAL_SLOTS     = NUM_GROUPS * GROUP_SLOTS;

  // Port field widths.
  localparam int MODE_W = 2;
  localparam int SLOT_W = 14;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TOP,
    ST_RD,
    ST_CHK,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_group;
    logic rd;
    logic w_inc;
    logic latch_bit;
    logic upd;
    logic set_nospace;
    logic set_query;
    logic load_out;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic is_query;
    logic top_full;
    logic word_full;
    logic w_last;
    logic bit_set;
    logic in_range;
    logic out_free;
    logic clear_last;
  } stat_t;

  // Index of the lowest zero bit; 63 when none below bit 63 is zero.
  function automatic logic [5:0] lowest_clear64(input logic [63:0] w);
    logic [5:0] idx;
    idx = 6'd63;
    for (int i = 62; i >= 0; i--) begin
      if (!w[i]) idx = 6'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/tlbsa_req_if.sv =====
`timescale 1ns / 1ps

interface tlbsa_req_if;
  logic                        valid;
  logic                        ready;
  logic [tlbsa_pkg::MODE_W-1:0] mode;
  logic [tlbsa_pkg::SLOT_W-1:0] slot_number;

  modport source (output valid, output mode, output slot_number, input ready);
  modport sink   (input valid, input mode, input slot_number, output ready);
endinterface

// ===== rtl/tlbsa_rsp_if.sv =====
`timescale 1ns / 1ps

interface tlbsa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tlbsa_pkg::SLOT_W-1:0] granted_slot;
  logic                        status;
  logic                        slot_is_empty;

  modport source (output valid, output granted_slot, output status, output slot_is_empty,
                  input ready);
  modport sink   (input valid, input granted_slot, input status, input slot_is_empty,
                  output ready);
endinterface

// ===== rtl/tlbsa_ram.sv =====
`timescale 1ns / 1ps

module tlbsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tlbsa_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlbsa_dp (
  input  logic              clk,
  input  logic              rst,
  input  tlbsa_pkg::cmd_t   cmd,
  output tlbsa_pkg::stat_t  stat,
  tlbsa_req_if.sink         req,
  tlbsa_rsp_if.source       rsp
);

  localparam int GW = tlbsa_pkg::GROUP_W;
  localparam int WW = tlbsa_pkg::WSEL_W;
  localparam int AW = tlbsa_pkg::ADDR_W;
  localparam int SB = tlbsa_pkg::SLOT_BITS;
  localparam int CW = tlbsa_pkg::CNT_W;
  localparam int SW = tlbsa_pkg::SLOT_W;

  logic [tlbsa_pkg::MODE_W-1:0]   mode_q;
  logic [SW-1:0]                  slot_q;
  logic [GW-1:0]                  group_q;
  logic [WW-1:0]                  wsel_q;
  logic [5:0]                     bit_q;
  logic [tlbsa_pkg::NUM_GROUPS-1:0] full_map;
  logic [AW-1:0]                  clr_cnt;

  logic [SW-1:0] res_granted;
  logic          res_status;
  logic          res_empty;
  logic          out_valid;
  logic [SW-1:0] out_granted;
  logic          out_status;
  logic          out_empty;

  logic [SB-1:0] slot_ext;
  logic [AW-1:0] slot_word;
  logic [GW-1:0] slot_group;
  logic [5:0]    slot_bit;
  logic [GW-1:0] free_group;
  logic          is_alloc;

  logic [AW-1:0] word_addr;
  logic [GW-1:0] cnt_addr;
  logic [63:0]   word_rdata;
  logic [CW-1:0] cnt_rdata;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] cnt_dec;

  logic          word_we;
  logic [AW-1:0] word_waddr;
  logic [63:0]   word_wdata;
  logic          cnt_we;
  logic [GW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  assign is_alloc   = (mode_q == tlbsa_pkg::MODE_ALLOC);
  assign slot_ext   = SB'(slot_q);
  assign slot_word  = slot_ext[SB-1:6];
  assign slot_group = slot_ext[SB-1:6+WW];
  assign slot_bit   = slot_ext[5:0];

  // Lowest group whose full bit is clear.
  always_comb begin
    free_group = '0;
    for (int i = tlbsa_pkg::NUM_GROUPS - 1; i >= 0; i--) begin
      if (!full_map[i]) free_group = GW'(i);
    end
  end

  assign word_addr = is_alloc ? {group_q, wsel_q} : slot_word;
  assign cnt_addr  = is_alloc ? group_q : slot_group;
  assign cnt_inc   = cnt_rdata + CW'(1);
  assign cnt_dec   = (cnt_rdata != '0) ? cnt_rdata - CW'(1) : cnt_rdata;

  always_comb begin
    word_we    = cmd.clear_step || cmd.upd;
    word_waddr = cmd.clear_step ? clr_cnt : word_addr;
    if (cmd.clear_step) begin
      word_wdata = '0;
    end else if (is_alloc) begin
      word_wdata = word_rdata | (64'd1 << bit_q);
    end else begin
      word_wdata = word_rdata & ~(64'd1 << slot_bit);
    end
    cnt_we    = cmd.clear_step || cmd.upd;
    cnt_waddr = cmd.clear_step ? clr_cnt[GW-1:0] : cnt_addr;
    if (cmd.clear_step) begin
      cnt_wdata = '0;
    end else if (is_alloc) begin
      cnt_wdata = cnt_inc;
    end else begin
      cnt_wdata = cnt_dec;
    end
  end

  tlbsa_ram #(.WIDTH(64), .DEPTH(tlbsa_pkg::NUM_WORDS)) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .re    (cmd.rd),
    .raddr (word_addr),
    .rdata (word_rdata)
  );

  tlbsa_ram #(.WIDTH(CW), .DEPTH(tlbsa_pkg::NUM_GROUPS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cmd.rd),
    .raddr (cnt_addr),
    .rdata (cnt_rdata)
  );

  // Request payload and scan position.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q <= req.mode;
      slot_q <= req.slot_number;
    end
    if (cmd.load_group) begin
      group_q <= free_group;
      wsel_q  <= '0;
    end else if (cmd.w_inc) begin
      wsel_q <= wsel_q + WW'(1);
    end
    if (cmd.latch_bit) bit_q <= tlbsa_pkg::lowest_clear64(word_rdata);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_map <= '0;
      clr_cnt  <= '0;
    end else begin
      if (cmd.clear_step) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.upd) begin
        if (is_alloc) begin
          if (32'(cnt_inc) >= tlbsa_pkg::GROUP_SLOTS) full_map[group_q] <= 1'b1;
        end else begin
          full_map[slot_group] <= 1'b0;
        end
      end
    end
  end

  // Result being built.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_granted <= '0;
      res_status  <= 1'b0;
      res_empty   <= 1'b0;
    end else begin
      if (cmd.set_nospace) res_status <= 1'b1;
      if (cmd.upd && is_alloc) res_granted <= SW'({group_q, wsel_q, bit_q});
      if (cmd.set_query) res_empty <= stat.in_range && !stat.bit_set;
    end
  end

  // Output register; frees the core while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_granted <= res_granted;
      out_status  <= res_status;
      out_empty   <= res_empty;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.granted_slot  = out_granted;
  assign rsp.status        = out_status;
  assign rsp.slot_is_empty = out_empty;

  always_comb begin
    stat.is_alloc   = is_alloc;
    stat.is_free    = (mode_q == tlbsa_pkg::MODE_FREE);
    stat.is_query   = (mode_q == tlbsa_pkg::MODE_QUERY);
    stat.top_full   = &full_map;
    stat.word_full  = &word_rdata;
    stat.w_last     = (wsel_q == WW'(tlbsa_pkg::WORDS_PER_GROUP - 1));
    stat.bit_set    = word_rdata[slot_bit];
    stat.in_range   = (32'(slot_q) < tlbsa_pkg::TOTAL_SLOTS);
    stat.out_free   = !out_valid || rsp.ready;
    stat.clear_last = (clr_cnt == AW'(tlbsa_pkg::NUM_WORDS - 1));
  end

  `ASSERT_IMPLY(a_nospace_zero, clk, rst, out_valid && out_status,
                out_granted == '0 && !out_empty, "no-space result carries a slot")
  `ASSERT_IMPLY(a_alloc_open_group, clk, rst, cmd.upd && is_alloc,
                !full_map[group_q], "allocate into a full group")
  `ASSERT_NEXT(a_free_clears_full, clk, rst, cmd.upd && !is_alloc,
               !full_map[$past(slot_group)], "free left group marked full")

endmodule

// ===== rtl/tlbsa_ctrl.sv =====
`timescale 1ns / 1ps

module tlbsa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  tlbsa_pkg::stat_t stat,
  output tlbsa_pkg::cmd_t  cmd
);

  tlbsa_pkg::state_t state;
  tlbsa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlbsa_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tlbsa_pkg::ST_CLEAR: begin
        if (stat.clear_last) state_next = tlbsa_pkg::ST_IDLE;
      end
      tlbsa_pkg::ST_IDLE: begin
        if (req_valid) state_next = tlbsa_pkg::ST_TOP;
      end
      tlbsa_pkg::ST_TOP: begin
        priority if (stat.is_alloc) begin
          state_next = stat.top_full ? tlbsa_pkg::ST_DONE : tlbsa_pkg::ST_RD;
        end else if (stat.is_free || stat.is_query) begin
          state_next = tlbsa_pkg::ST_RD;
        end else begin
          state_next = tlbsa_pkg::ST_DONE;
        end
      end
      tlbsa_pkg::ST_RD: begin
        state_next = tlbsa_pkg::ST_CHK;
      end
      tlbsa_pkg::ST_CHK: begin
        priority if (stat.is_alloc) begin
          if (!stat.word_full) begin
            state_next = tlbsa_pkg::ST_UPD;
          end else if (stat.w_last) begin
            state_next = tlbsa_pkg::ST_DONE;
          end else begin
            state_next = tlbsa_pkg::ST_RD;
          end
        end else if (stat.is_free && stat.in_range && stat.bit_set) begin
          state_next = tlbsa_pkg::ST_UPD;
        end else begin
          state_next = tlbsa_pkg::ST_DONE;
        end
      end
      tlbsa_pkg::ST_UPD: begin
        state_next = tlbsa_pkg::ST_DONE;
      end
      tlbsa_pkg::ST_DONE: begin
        if (stat.out_free) state_next = tlbsa_pkg::ST_IDLE;
      end
      default: state_next = tlbsa_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      tlbsa_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      tlbsa_pkg::ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      tlbsa_pkg::ST_TOP: begin
        cmd.load_group  = 1'b1;
        cmd.set_nospace = stat.is_alloc && stat.top_full;
      end
      tlbsa_pkg::ST_RD: cmd.rd = 1'b1;
      tlbsa_pkg::ST_CHK: begin
        if (stat.is_alloc) begin
          cmd.latch_bit   = !stat.word_full;
          cmd.w_inc       = stat.word_full && !stat.w_last;
          cmd.set_nospace = stat.word_full && stat.w_last;
        end
        cmd.set_query = stat.is_query;
      end
      tlbsa_pkg::ST_UPD: cmd.upd = 1'b1;
      tlbsa_pkg::ST_DONE: cmd.load_out = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/two_level_bitmap_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
// Two-level bitmap slot allocator.
// Requests arrive on req (valid/ready): mode 0 allocates the lowest free slot
// of the lowest group not marked full, mode 1 frees slot_number, mode 2 asks
// whether slot_number is empty. Mode 3 changes nothing and answers zeros.
// Each request gives one result on rsp (valid/ready): granted_slot, status
// (1 = no free slot on allocate) and slot_is_empty.
// One request is worked at a time; DONE loads the result. States per mode:
//   mode 3 ................. TOP, DONE
//   query, free ............ TOP, RD, CHK, DONE; UPD before DONE when a free
//                            clears a bit
//   allocate ............... TOP, RD, CHK, UPD, DONE, with RD, CHK again for
//                            each full word; TOP, DONE if all groups full.
// The next request can be taken in the cycle after the result is loaded.
// The pace is set by the slot word memory: one word is read, tested and
// written back per step.
// After reset the block runs a clearing pass over all 256 slot words and the
// fill-count memory with req.ready low; the full map clears at once.
// A finished result sits in an output register, so rsp stalls do not block
// the next request until a second result is ready to be presented.
module two_level_bitmap_slot_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  tlbsa_req_if.sink   req,
  tlbsa_rsp_if.source rsp
);

  tlbsa_pkg::cmd_t  cmd;
  tlbsa_pkg::stat_t stat;
  logic             ready;

  assign req.ready = ready;

  tlbsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tlbsa_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

endmodule
